// File: rtl/core/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and fixed constants of the HSV to RGB color converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // Q0.16 color channels, 1.0 = 65536, so one extra bit holds full scale.
   localparam int COLOR_FRAC_BITS = 16;
   localparam int CHAN_W          = 17;
   localparam int VS_W            = 2 * CHAN_W - 1;
   localparam logic [CHAN_W-1:0] UNIT_ONE = CHAN_W'(1 << COLOR_FRAC_BITS);
   localparam logic [VS_W-1:0]   CHROMA_HALF = VS_W'(1 << (COLOR_FRAC_BITS - 1));

   // Hue is Q.8 degrees in [0, 92160); 92160 = 45 * 2^11.
   localparam int HUE_W     = 17;
   localparam int HUE_LOW_W = 11;
   localparam int HUE_BLK_W = 22;
   localparam int HUE_REM_W = 6;
   localparam logic [HUE_BLK_W-1:0] HUE_BLK_BIAS = 22'd1048590;  // 45 * 23302
   localparam logic [HUE_REM_W-1:0] HUE_BLOCKS   = 6'd45;
   localparam logic [22:0]          RECIP45       = 23'd5965233;  // ceil(2^28 / 45)
   localparam int                   RECIP45_SHIFT = 28;
   localparam int                   QUO45_W       = 17;

   // Golden-ratio fraction as Q0.32.
   localparam logic [31:0] GOLDEN_Q32 = 32'h9E3779B9;
   localparam int          GOLD45_W   = 38;

   // One 60 degree sector in Q.8 degrees; 15360 = 15 * 2^10.
   localparam logic [HUE_W-1:0] HUE_SECTOR = 17'd15360;
   localparam int               F_W        = 14;
   localparam int               PROD_W     = CHAN_W + F_W;
   localparam logic [12:0]      X_HALF     = 13'd7680;
   localparam int               T_W        = 21;
   localparam logic [20:0]      RECIP15    = 21'd1118482;  // ceil(2^24 / 15)
   localparam int               RECIP15_SHIFT = 24;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [HUE_W-1:0]  hue_type;

   typedef enum logic [2:0] {
      SECTOR_R_TO_Y = 3'd0,
      SECTOR_Y_TO_G = 3'd1,
      SECTOR_G_TO_C = 3'd2,
      SECTOR_C_TO_B = 3'd3,
      SECTOR_B_TO_M = 3'd4,
      SECTOR_M_TO_R = 3'd5
   } sector_type;

endpackage

// File: rtl/core/hsvrgb_if.sv
// ----------------------------------------------------------------------------
// hsvrgb_if
// Valid/ready channels carrying HSV requests and RGB responses.
// ----------------------------------------------------------------------------
interface hsvrgb_in_if;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [31:0]       hue_deg;
   logic [31:0]              color_index;
   hsvrgb_pkg::chan_type     saturation;
   hsvrgb_pkg::chan_type     brightness;

   modport source (output valid, kind, hue_deg, color_index, saturation, brightness,
                   input ready);
   modport sink   (input valid, kind, hue_deg, color_index, saturation, brightness,
                   output ready);
endinterface

interface hsvrgb_out_if;
   logic                 valid;
   logic                 ready;
   hsvrgb_pkg::chan_type red;
   hsvrgb_pkg::chan_type green;
   hsvrgb_pkg::chan_type blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/core/hsvrgb_hue.sv
// ----------------------------------------------------------------------------
// hsvrgb_hue
// Two-stage hue unit: wraps a signed degree hue or derives one from an index.
// ----------------------------------------------------------------------------
module hsvrgb_hue (
   input  logic                clock,
   input  logic                en,
   input  logic                kind,
   input  logic signed [31:0]  hue_deg,
   input  logic [31:0]         color_index,
   output hsvrgb_pkg::hue_type hue
);

   localparam int BW = hsvrgb_pkg::HUE_BLK_W;
   localparam int LW = hsvrgb_pkg::HUE_LOW_W;

   logic [BW-1:0]                     blk_in;
   logic [BW+22:0]                    quo_prod;
   logic [63:0]                       gold_prod;
   logic                              kind_a_ff;
   logic [LW-1:0]                     low_a_ff;
   logic [BW-1:0]                     blk_a_ff;
   logic [hsvrgb_pkg::QUO45_W-1:0]    quo_a_ff;
   logic [31:0]                       frac_a_ff;
   logic [BW-1:0]                     rem_full;
   logic [hsvrgb_pkg::GOLD45_W-1:0]   gold45;
   hsvrgb_pkg::hue_type               hue_in;
   hsvrgb_pkg::hue_type               hue_ff;

   // Floor-divide by 2^11, then bias by a multiple of 45 so the block count
   // is non-negative and keeps its residue modulo 45.
   assign blk_in   = {hue_deg[31], hue_deg[31:LW]} + hsvrgb_pkg::HUE_BLK_BIAS;
   assign quo_prod = (BW+23)'(blk_in) * (BW+23)'(hsvrgb_pkg::RECIP45);
   assign gold_prod = 64'(color_index) * 64'(hsvrgb_pkg::GOLDEN_Q32);

   always_ff @(posedge clock) begin
      if (en) begin
         kind_a_ff <= kind;
         low_a_ff  <= hue_deg[LW-1:0];
         blk_a_ff  <= blk_in;
         quo_a_ff  <= quo_prod[hsvrgb_pkg::RECIP45_SHIFT +: hsvrgb_pkg::QUO45_W];
         frac_a_ff <= gold_prod[31:0];
      end
   end

   // The reciprocal quotient is exact over the biased range, so the
   // remainder is below 45.
   assign rem_full = blk_a_ff - BW'(quo_a_ff) * BW'(hsvrgb_pkg::HUE_BLOCKS);
   assign gold45   = hsvrgb_pkg::GOLD45_W'(frac_a_ff) * hsvrgb_pkg::GOLD45_W'(6'd45);

   always_comb begin
      if (kind_a_ff) begin
         hue_in = gold45[hsvrgb_pkg::GOLD45_W-1 -: hsvrgb_pkg::HUE_W];
      end else begin
         hue_in = {rem_full[hsvrgb_pkg::HUE_REM_W-1:0], low_a_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff <= hue_in;
      end
   end

   assign hue = hue_ff;

endmodule

// File: rtl/core/hsvrgb_mix.sv
// ----------------------------------------------------------------------------
// hsvrgb_mix
// Three-stage sector, secondary-component and channel assembly pipeline.
// ----------------------------------------------------------------------------
module hsvrgb_mix (
   input  logic                 clock,
   input  logic                 en,
   input  hsvrgb_pkg::hue_type  hue,
   input  hsvrgb_pkg::chan_type chroma,
   input  hsvrgb_pkg::chan_type value,
   output hsvrgb_pkg::chan_type red,
   output hsvrgb_pkg::chan_type green,
   output hsvrgb_pkg::chan_type blue
);

   localparam int PW = hsvrgb_pkg::PROD_W;
   localparam int TW = hsvrgb_pkg::T_W;
   localparam int XW = hsvrgb_pkg::CHAN_W;

   hsvrgb_pkg::sector_type            sector_in, sector_c_ff, sector_d_ff;
   hsvrgb_pkg::hue_type               base;
   hsvrgb_pkg::hue_type               pos;
   logic [hsvrgb_pkg::F_W-1:0]        f_val;
   logic [PW-1:0]                     prod_c_ff;
   hsvrgb_pkg::chan_type              c_c_ff, m_c_ff, c_d_ff, m_d_ff;
   logic [PW:0]                       round_sum;
   logic [TW-1:0]                     t_val;
   logic [TW+20:0]                    x_prod;
   hsvrgb_pkg::chan_type              x_d_ff;
   hsvrgb_pkg::chan_type              r_pre, g_pre, b_pre;
   hsvrgb_pkg::chan_type              red_ff, green_ff, blue_ff;

   always_comb begin
      if (hue >= 17'(5 * hsvrgb_pkg::HUE_SECTOR)) begin
         sector_in = hsvrgb_pkg::SECTOR_M_TO_R;
         base      = 17'(5 * hsvrgb_pkg::HUE_SECTOR);
      end else if (hue >= 17'(4 * hsvrgb_pkg::HUE_SECTOR)) begin
         sector_in = hsvrgb_pkg::SECTOR_B_TO_M;
         base      = 17'(4 * hsvrgb_pkg::HUE_SECTOR);
      end else if (hue >= 17'(3 * hsvrgb_pkg::HUE_SECTOR)) begin
         sector_in = hsvrgb_pkg::SECTOR_C_TO_B;
         base      = 17'(3 * hsvrgb_pkg::HUE_SECTOR);
      end else if (hue >= 17'(2 * hsvrgb_pkg::HUE_SECTOR)) begin
         sector_in = hsvrgb_pkg::SECTOR_G_TO_C;
         base      = 17'(2 * hsvrgb_pkg::HUE_SECTOR);
      end else if (hue >= hsvrgb_pkg::HUE_SECTOR) begin
         sector_in = hsvrgb_pkg::SECTOR_Y_TO_G;
         base      = hsvrgb_pkg::HUE_SECTOR;
      end else begin
         sector_in = hsvrgb_pkg::SECTOR_R_TO_Y;
         base      = '0;
      end
      pos = hue - base;
      // The ramp falls across odd sectors and rises across even ones.
      if (sector_in[0]) begin
         f_val = hsvrgb_pkg::F_W'(hsvrgb_pkg::HUE_SECTOR - pos);
      end else begin
         f_val = hsvrgb_pkg::F_W'(pos);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sector_c_ff <= sector_in;
         prod_c_ff   <= PW'(chroma) * PW'(f_val);
         c_c_ff      <= chroma;
         m_c_ff      <= value - chroma;
      end
   end

   // Divide by 15360 with rounding: shift out 2^10, then a reciprocal
   // multiply for the factor 15, which is exact over this range.
   assign round_sum = (PW+1)'(prod_c_ff) + (PW+1)'(hsvrgb_pkg::X_HALF);
   assign t_val     = round_sum[10 +: TW];
   assign x_prod    = (TW+21)'(t_val) * (TW+21)'(hsvrgb_pkg::RECIP15);

   always_ff @(posedge clock) begin
      if (en) begin
         sector_d_ff <= sector_c_ff;
         x_d_ff      <= x_prod[hsvrgb_pkg::RECIP15_SHIFT +: XW];
         c_d_ff      <= c_c_ff;
         m_d_ff      <= m_c_ff;
      end
   end

   always_comb begin
      case (sector_d_ff)
         hsvrgb_pkg::SECTOR_R_TO_Y: begin
            r_pre = c_d_ff; g_pre = x_d_ff; b_pre = '0;
         end
         hsvrgb_pkg::SECTOR_Y_TO_G: begin
            r_pre = x_d_ff; g_pre = c_d_ff; b_pre = '0;
         end
         hsvrgb_pkg::SECTOR_G_TO_C: begin
            r_pre = '0; g_pre = c_d_ff; b_pre = x_d_ff;
         end
         hsvrgb_pkg::SECTOR_C_TO_B: begin
            r_pre = '0; g_pre = x_d_ff; b_pre = c_d_ff;
         end
         hsvrgb_pkg::SECTOR_B_TO_M: begin
            r_pre = x_d_ff; g_pre = '0; b_pre = c_d_ff;
         end
         default: begin
            r_pre = c_d_ff; g_pre = '0; b_pre = x_d_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= r_pre + m_d_ff;
         green_ff <= g_pre + m_d_ff;
         blue_ff  <= b_pre + m_d_ff;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

// File: rtl/core/hsv_to_rgb_converter.sv
// Path: a transaction accepted into the first register stage moves through the
// stages in order, is presented as a response from the output register and
// leaves when the response channel takes it.
// Throughput: one transaction per cycle; the five register stages advance
// together whenever the output register is empty or being taken.
// Reset: synchronous and active high; it clears every stage valid bit, so no
// response is shown after reset. Payload registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to RGB color conversion, one color per transaction.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic          clock,
   input  logic          reset,
   hsvrgb_in_if.sink     req_chan,
   hsvrgb_out_if.source  rsp_chan
);

   localparam int STAGES = 5;
   localparam int CW     = hsvrgb_pkg::CHAN_W;
   localparam int VSW    = hsvrgb_pkg::VS_W;

   // All stages move on a single enable. The last stage is the output
   // register, so a stalled response holds the pipeline in place without
   // dropping or duplicating anything, and a new transaction is taken in the
   // same cycle that the current response leaves.
   logic                 advance;
   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    valid_in;

   hsvrgb_pkg::chan_type sat_clamped, val_clamped;
   logic [VSW-1:0]       vs_a_ff;
   hsvrgb_pkg::chan_type v_a_ff;
   logic [VSW-1:0]       chroma_sum;
   hsvrgb_pkg::chan_type c_b_ff, v_b_ff;
   hsvrgb_pkg::hue_type  hue_b;

   assign advance       = !valid_ff[STAGES-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign rsp_chan.valid = valid_ff[STAGES-1];

   assign valid_in = {valid_ff[STAGES-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage one: clamp saturation and value to 1.0 and form their product.
   always_comb begin
      sat_clamped = (req_chan.saturation > hsvrgb_pkg::UNIT_ONE) ?
                    hsvrgb_pkg::UNIT_ONE : req_chan.saturation;
      val_clamped = (req_chan.brightness > hsvrgb_pkg::UNIT_ONE) ?
                    hsvrgb_pkg::UNIT_ONE : req_chan.brightness;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vs_a_ff <= VSW'(val_clamped) * VSW'(sat_clamped);
         v_a_ff  <= val_clamped;
      end
   end

   // Stage two: chroma is the product rounded half up back to Q0.16.
   assign chroma_sum = vs_a_ff + hsvrgb_pkg::CHROMA_HALF;

   always_ff @(posedge clock) begin
      if (advance) begin
         c_b_ff <= chroma_sum[hsvrgb_pkg::COLOR_FRAC_BITS +: CW];
         v_b_ff <= v_a_ff;
      end
   end

   // The hue unit runs in step with the chroma path over stages one and two.
   hsvrgb_hue u_hue (
      .clock       (clock),
      .en          (advance),
      .kind        (req_chan.kind),
      .hue_deg     (req_chan.hue_deg),
      .color_index (req_chan.color_index),
      .hue         (hue_b)
   );

   // Stages three to five: sector and ramp, the secondary component, and the
   // channel placement with the offset m = v - c added in the output register.
   hsvrgb_mix u_mix (
      .clock  (clock),
      .en     (advance),
      .hue    (hue_b),
      .chroma (c_b_ff),
      .value  (v_b_ff),
      .red    (rsp_chan.red),
      .green  (rsp_chan.green),
      .blue   (rsp_chan.blue)
   );

endmodule

// File: rtl/core/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks of the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hsvrgb_pkg::chan_type red,
   input hsvrgb_pkg::chan_type green,
   input hsvrgb_pkg::chan_type blue
);

   // No response may be pending in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its transaction.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(red) && $stable(green)
                                  && $stable(blue))
      else $error("stalled response changed");

   // The converter takes input whenever its output register is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input not ready while output can move");

   // Every channel stays within full scale.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> red <= hsvrgb_pkg::UNIT_ONE && green <= hsvrgb_pkg::UNIT_ONE
                    && blue <= hsvrgb_pkg::UNIT_ONE)
      else $error("channel above full scale");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .red       (rsp_chan.red),
   .green     (rsp_chan.green),
   .blue      (rsp_chan.blue)
);

// File: tb/hsv_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB converter. A directed table walks the
// primary and secondary hues, hue wrap, clamping and the unused hue source,
// then about a thousand random colors follow. Every response is compared field
// by field with a local fixed-point model of the conversion, or with a hand
// answer on some directed rows, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_COLORS    = 1080;
   // The first random colors go back to back to keep the pipeline full.
   localparam int BURST_COLORS     = 150;
   // After this many transactions the response side holds off for a long stretch.
   localparam int HOLD_AFTER       = 300;
   localparam int LONG_HOLD_CYCLES = 300;
   // At this random color the request side waits for every response to return.
   localparam int DRAIN_AT         = 700;
   localparam int TAIL_CYCLES      = 20;
   localparam int IDLE_LIMIT       = 4000;
   localparam int MAX_REPORTS      = 10;

   // Hue is Q.8 degrees: a full turn is 360 * 256 and a sector is 60 * 256.
   localparam int              HUE_DEG     = 256;
   localparam longint unsigned HUE_TURN    = 92160;
   localparam longint unsigned HUE_SIXTH   = 15360;
   localparam longint unsigned GOLDEN_FRAC = 64'h9E37_79B9;
   localparam longint unsigned CHAN_ONE    = 64'd1 << hsvrgb_pkg::COLOR_FRAC_BITS;
   localparam longint unsigned CHROMA_RND  = 64'd1 << (hsvrgb_pkg::COLOR_FRAC_BITS - 1);
   localparam hsvrgb_pkg::chan_type ONE    = hsvrgb_pkg::chan_type'(CHAN_ONE);

   typedef struct packed {
      logic                 kind;
      logic signed [31:0]   hue_deg;
      logic [31:0]          color_index;
      hsvrgb_pkg::chan_type saturation;
      hsvrgb_pkg::chan_type brightness;
   } hsv_color_type;

   typedef struct packed {
      hsvrgb_pkg::chan_type red;
      hsvrgb_pkg::chan_type green;
      hsvrgb_pkg::chan_type blue;
   } rgb_color_type;

   // A directed row carries its own answer only when it is obvious by eye.
   typedef struct packed {
      hsv_color_type color;
      logic          known;
      rgb_color_type rgb;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   hsvrgb_in_if  req_chan ();
   hsvrgb_out_if rsp_chan ();

   directed_row_type directed_rows[$];
   rgb_color_type    rgb_pending[$];
   int               mismatches  = 0;
   int               colors_sent = 0;
   int               idle_cycles = 0;
   bit               hold_done   = 1'b0;

   hsv_to_rgb_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Fixed-point conversion of one color. The hue is first brought into
   // [0, 360) degrees, either by wrapping the signed degree input or from the
   // golden-ratio walk over the palette index. Chroma and the secondary
   // component are then placed on the channels by sector and lifted by m.
   function automatic rgb_color_type predict_rgb(input hsv_color_type color);
      longint unsigned        sat, val, chroma, xval, mval;
      longint unsigned        hue_q8, pos, weight, idx, frac;
      longint unsigned        red, green, blue;
      longint                 signed_hue;
      hsvrgb_pkg::sector_type sector;
      rgb_color_type          rgb;
      sat = (color.saturation > CHAN_ONE) ? CHAN_ONE : color.saturation;
      val = (color.brightness > CHAN_ONE) ? CHAN_ONE : color.brightness;
      if (color.kind) begin
         idx    = color.color_index;
         frac   = (idx * GOLDEN_FRAC) & 64'hFFFF_FFFF;
         hue_q8 = (frac * HUE_TURN) >> 32;
      end else begin
         signed_hue = $signed(color.hue_deg);
         signed_hue = signed_hue % 92160;
         if (signed_hue < 0) begin
            signed_hue = signed_hue + 92160;
         end
         hue_q8 = signed_hue;
      end
      chroma = (val * sat + CHROMA_RND) >> hsvrgb_pkg::COLOR_FRAC_BITS;
      sector = hsvrgb_pkg::sector_type'(hue_q8 / HUE_SIXTH);
      pos    = hue_q8 % HUE_SIXTH;
      // The secondary component rises in even sectors and falls in odd ones.
      weight = sector[0] ? (HUE_SIXTH - pos) : pos;
      xval   = (chroma * weight + HUE_SIXTH / 2) / HUE_SIXTH;
      mval   = val - chroma;
      case (sector)
         hsvrgb_pkg::SECTOR_R_TO_Y: begin
            red = chroma; green = xval;   blue = 0;
         end
         hsvrgb_pkg::SECTOR_Y_TO_G: begin
            red = xval;   green = chroma; blue = 0;
         end
         hsvrgb_pkg::SECTOR_G_TO_C: begin
            red = 0;      green = chroma; blue = xval;
         end
         hsvrgb_pkg::SECTOR_C_TO_B: begin
            red = 0;      green = xval;   blue = chroma;
         end
         hsvrgb_pkg::SECTOR_B_TO_M: begin
            red = xval;   green = 0;      blue = chroma;
         end
         default: begin
            red = chroma; green = 0;      blue = xval;
         end
      endcase
      rgb.red   = hsvrgb_pkg::chan_type'(red + mval);
      rgb.green = hsvrgb_pkg::chan_type'(green + mval);
      rgb.blue  = hsvrgb_pkg::chan_type'(blue + mval);
      return rgb;
   endfunction

   function automatic void add_row(input logic kind, input logic [31:0] hue,
                                   input logic [31:0] index,
                                   input hsvrgb_pkg::chan_type sat,
                                   input hsvrgb_pkg::chan_type val,
                                   input logic known = 1'b0,
                                   input hsvrgb_pkg::chan_type red = '0,
                                   input hsvrgb_pkg::chan_type green = '0,
                                   input hsvrgb_pkg::chan_type blue = '0);
      directed_row_type row;
      row.color.kind        = kind;
      row.color.hue_deg     = hue;
      row.color.color_index = index;
      row.color.saturation  = sat;
      row.color.brightness  = val;
      row.known             = known;
      row.rgb.red           = red;
      row.rgb.green         = green;
      row.rgb.blue          = blue;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int random_gap(input bit burst);
      int pick;
      pick = $urandom_range(0, 99);
      if (burst || pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Saturation and value: mostly in range, sometimes above full scale so
   // that the clamp and the top bit are exercised, and sometimes an edge.
   function automatic hsvrgb_pkg::chan_type random_unit();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 5))
               0:       return 17'd0;
               1:       return 17'd1;
               2:       return 17'd65535;
               3:       return 17'd65536;
               4:       return 17'd65537;
               default: return 17'h1FFFF;
            endcase
         end
         1:       return hsvrgb_pkg::chan_type'($urandom_range(65536, 131071));
         default: return hsvrgb_pkg::chan_type'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic hsv_color_type random_color();
      hsv_color_type color;
      color.kind        = 1'($urandom_range(0, 1));
      color.color_index = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255);
      case ($urandom_range(0, 3))
         0: color.hue_deg = $urandom;
         // A few turns either side of zero, so the wrap is taken both ways.
         1: color.hue_deg = int'($urandom_range(0, 6 * 92160)) - 3 * 92160;
         // Right on a sector boundary or one step beside it.
         2: color.hue_deg = (int'($urandom_range(0, 18)) - 6) * 15360
                            + int'($urandom_range(0, 2)) - 1;
         default: color.hue_deg = $urandom_range(0, 92159);
      endcase
      color.saturation = random_unit();
      color.brightness = random_unit();
      return color;
   endfunction

   // Offers one transaction and holds it until the converter takes it. The
   // expected response is queued at the accepting edge. The valid line is
   // lowered only for a real gap, so back-to-back transactions keep it high.
   task automatic offer_color(input hsv_color_type color, input rgb_color_type rgb,
                              input int gap);
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= color.kind;
      req_chan.hue_deg     <= color.hue_deg;
      req_chan.color_index <= color.color_index;
      req_chan.saturation  <= color.saturation;
      req_chan.brightness  <= color.brightness;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      rgb_pending.insert(rgb_pending.size(), rgb);
      colors_sent++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Request side: reset, the directed table, then the random colors.
   initial begin : request_side
      hsv_color_type color;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= 1'b0;
      req_chan.hue_deg     <= '0;
      req_chan.color_index <= '0;
      req_chan.saturation  <= '0;
      req_chan.brightness  <= '0;
      rsp_chan.ready       <= 1'b0;

      // Primary and secondary colors land exactly on sector starts.
      add_row(0, 0,             0, ONE, ONE, 1, ONE, 0,   0);
      add_row(0, 60 * HUE_DEG,  0, ONE, ONE, 1, ONE, ONE, 0);
      add_row(0, 120 * HUE_DEG, 0, ONE, ONE, 1, 0,   ONE, 0);
      add_row(0, 180 * HUE_DEG, 0, ONE, ONE, 1, 0,   ONE, ONE);
      add_row(0, 240 * HUE_DEG, 0, ONE, ONE, 1, 0,   0,   ONE);
      add_row(0, 300 * HUE_DEG, 0, ONE, ONE, 1, ONE, 0,   ONE);
      // A full turn and negative hues wrap back into the first turn.
      add_row(0, 360 * HUE_DEG,  0, ONE, ONE, 1, ONE, 0, 0);
      add_row(0, -360 * HUE_DEG, 0, ONE, ONE, 1, ONE, 0, 0);
      add_row(0, -120 * HUE_DEG, 0, ONE, ONE, 1, 0,   0, ONE);
      add_row(0, 32'hFFFF_FFFF, 0,             ONE, ONE);
      add_row(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, ONE, ONE);
      add_row(0, 32'h8000_0000, 0,             ONE, ONE);
      // Just short of the second sector, and a half-scale color for rounding.
      add_row(0, 15359,        0, ONE,    ONE);
      add_row(0, 30 * HUE_DEG, 0, 32768, 32768);
      // No saturation gives gray at the value; no value gives black.
      add_row(0, 90 * HUE_DEG,  0, 0,   ONE, 1, ONE, ONE, ONE);
      add_row(0, 200 * HUE_DEG, 0, ONE, 0,   1, 0,   0,   0);
      // Saturation and value above full scale are clamped to full scale.
      add_row(0, 0,             0, 17'h1FFFF, ONE,       1, ONE, 0,   0);
      add_row(0, 0,             0, 0,         17'h1FFFF, 1, ONE, ONE, ONE);
      add_row(0, 120 * HUE_DEG, 0, 17'd65537, 17'd65537, 1, 0,   ONE, 0);
      // Each kind ignores the other hue source; index zero means hue zero.
      add_row(0, 0,             32'hFFFF_FFFF, ONE, ONE, 1, ONE, 0, 0);
      add_row(1, 120 * HUE_DEG, 0,             ONE, ONE, 1, ONE, 0, 0);
      add_row(1, 0,             1,             ONE, ONE);
      add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ONE, ONE);
      add_row(1, 0,             32'h8000_0000, 17'd40000, 17'd50000);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_color(directed_rows[i].color,
                     directed_rows[i].known ? directed_rows[i].rgb
                                            : predict_rgb(directed_rows[i].color),
                     random_gap(1'b0));
      end

      for (int n = 0; n < RANDOM_COLORS; n++) begin
         // Once in the run, stop offering until the pipeline is empty.
         if (n == DRAIN_AT) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (rgb_pending.size() != 0);
         end
         color = random_color();
         offer_color(color, predict_rgb(color), random_gap(n < BURST_COLORS));
      end
      req_chan.valid <= 1'b0;

      // Let the pipeline empty, then watch a while for stray responses.
      while (rgb_pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && rgb_pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Response side: ready runs of random length separated by random stalls,
   // with an occasional long run so that there are stretches without stalls.
   // Once enough transactions have gone in, ready is held low long enough for
   // the converter to fill up and push back on the request side.
   initial begin : response_side
      int run;
      int stall;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (!hold_done && colors_sent >= HOLD_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
         rsp_chan.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = random_gap(1'b0);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Every accepted response is matched against the oldest expected color.
   always @(posedge clock) begin : rgb_check
      rgb_color_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (rgb_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: response with none expected: r=%0d g=%0d b=%0d",
                        $realtime, rsp_chan.red, rsp_chan.green, rsp_chan.blue);
            end
         end else begin
            want = rgb_pending.pop_front();
            if (rsp_chan.red !== want.red || rsp_chan.green !== want.green ||
                rsp_chan.blue !== want.blue) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                           $realtime, want.red, want.green, want.blue,
                           rsp_chan.red, rsp_chan.green, rsp_chan.blue);
               end
            end
         end
      end
   end

   // Watchdog: too many cycles without a transaction on either side ends the
   // run. The limit is well above the long response hold-off.
   always @(posedge clock) begin : watchdog
      if (reset !== 1'b0 ||
          (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
